>>> rtl/axis_waypoint_sequencer_defines.svh
// Assertion macros used by the waypoint sequencer core (aws_core).
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef AXIS_WAYPOINT_SEQUENCER_DEFINES_SVH
`define AXIS_WAYPOINT_SEQUENCER_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define AWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer check failed");
// next-cycle implication
`define AWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer check failed");
`else
`define AWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/aws_pkg.sv
// Types and constants of the axis waypoint sequencer.
// No dependencies; used by every module of the block.
package aws_pkg;

  // sequencer state codes
  localparam logic [3:0] ST_ACTIVE = 4'd0;
  localparam logic [3:0] ST_POWER  = 4'd1;
  localparam logic [3:0] ST_HOMING = 4'd2;
  localparam logic [3:0] ST_WAIT   = 4'd3;
  localparam logic [3:0] ST_UPD    = 4'd4;
  localparam logic [3:0] ST_MOVE1  = 4'd5;
  localparam logic [3:0] ST_MOVE2  = 4'd6;
  localparam logic [3:0] ST_HUPD   = 4'd7;
  localparam logic [3:0] ST_HMOVE1 = 4'd8;
  localparam logic [3:0] ST_HMOVE2 = 4'd9;
  localparam logic [3:0] ST_STOP   = 4'd10;
  localparam logic [3:0] ST_ERROR  = 4'd11;

  // latched flag bit positions
  localparam int LF_HOME   = 0;
  localparam int LF_START  = 1;
  localparam int LF_STOP   = 2;
  localparam int LF_UPDATE = 3;
  localparam int LF_MOVE   = 4;
  localparam int LF_DHOME  = 5;

  // command bit positions
  localparam int CMD_HOME   = 0;
  localparam int CMD_START  = 1;
  localparam int CMD_STOP   = 2;
  localparam int CMD_POWER  = 3;
  localparam int CMD_ERESET = 4;

  // axis status bit positions
  localparam int AX_ACTIVE  = 0;
  localparam int AX_POWER   = 1;
  localparam int AX_HOMED   = 2;
  localparam int AX_ERROR   = 3;
  localparam int AX_UPDDONE = 4;
  localparam int AX_MOVING  = 5;
  localparam int AX_INPOS   = 6;

  // configuration register indexes
  localparam logic [1:0] CFG_WP_COUNT  = 2'd0;
  localparam logic [1:0] CFG_HOME_POS  = 2'd1;
  localparam logic [1:0] CFG_HOME_VEL  = 2'd2;
  localparam logic [1:0] CFG_HOME_ACC  = 2'd3;

  localparam logic [3:0]  RST_WP_COUNT = 4'd5;
  localparam logic [15:0] RST_HOME_POS = 16'd700;
  localparam logic [15:0] RST_HOME_VEL = 16'd500;
  localparam logic [19:0] RST_HOME_ACC = 20'd5000;

  localparam logic       REQ_TICK  = 1'b0;
  localparam logic       REQ_WRITE = 1'b1;

  typedef struct packed {
    logic [15:0] drive_position;
    logic [15:0] drive_velocity;
    logic [19:0] drive_acc_dec;
    logic        drive_power;
    logic        drive_home;
    logic        drive_error_reset;
    logic        drive_update;
    logic        drive_move;
    logic [3:0]  state_code;
    logic [2:0]  waypoint_number;
  } result_t;

  // default waypoint table, slots past the fifth are zero
  function automatic logic [15:0] init_pos(input int idx);
    logic [15:0] v;
    case (idx)
      0: v = 16'd100;
      1: v = 16'd1100;
      2: v = 16'd700;
      3: v = 16'd200;
      4: v = 16'd1200;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] init_vel(input int idx);
    logic [15:0] v;
    case (idx)
      0: v = 16'd500;
      1: v = 16'd1000;
      2: v = 16'd200;
      3: v = 16'd500;
      4: v = 16'd400;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/aws_wp_table.sv
// Waypoint table: one write port, one registered read port with write bypass.
// Uses aws_pkg for the default table contents shown until a slot is written.
module aws_wp_table #(
  parameter int MAX_WAYPOINTS = 8,
  parameter int PW            = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [PW-1:0] wr_addr,
  input  logic [15:0]   wr_pos,
  input  logic [15:0]   wr_vel,
  input  logic [PW-1:0] rd_addr,
  output logic [15:0]   rd_pos,
  output logic [15:0]   rd_vel
);

  logic [15:0] pos_mem [MAX_WAYPOINTS];
  logic [15:0] vel_mem [MAX_WAYPOINTS];
  logic [MAX_WAYPOINTS-1:0] written_r;

  logic [15:0]   rd_pos_r;
  logic [15:0]   rd_vel_r;
  logic [PW-1:0] rd_addr_r;
  logic          rd_dflt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      vel_mem[wr_addr] <= wr_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr_en) begin
      written_r[wr_addr] <= 1'b1;
    end
  end

  // write-first read so a slot written this cycle is seen next cycle
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_pos_r <= wr_pos;
      rd_vel_r <= wr_vel;
    end else begin
      rd_pos_r <= pos_mem[rd_addr];
      rd_vel_r <= vel_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
      rd_dflt_r <= 1'b1;
    end else begin
      rd_addr_r <= rd_addr;
      rd_dflt_r <= !(written_r[rd_addr] || (wr_en && (wr_addr == rd_addr)));
    end
  end

  assign rd_pos = rd_dflt_r ? aws_pkg::init_pos(int'(rd_addr_r)) : rd_pos_r;
  assign rd_vel = rd_dflt_r ? aws_pkg::init_vel(int'(rd_addr_r)) : rd_vel_r;

endmodule

>>> rtl/aws_core.sv
// Sequencer state machine, configuration registers and drive targets.
// Uses aws_pkg and the assertion macros; reads the waypoint table.
`include "axis_waypoint_sequencer_defines.svh"
module aws_core #(
  parameter int MAX_WAYPOINTS = 8,
  parameter int PW            = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [19:0]      cfg_data,
  input  logic             acc,
  input  logic             in_req_type,
  input  logic [2:0]       in_wp_index,
  input  logic [4:0]       in_commands,
  input  logic [6:0]       in_axis_status,
  input  logic [15:0]      rd_pos,
  input  logic [15:0]      rd_vel,
  output logic             wr_en,
  output logic [PW-1:0]    wr_addr,
  output logic [PW-1:0]    rd_addr,
  output aws_pkg::result_t result
);

  logic [3:0]  wp_count_r;
  logic [15:0] home_pos_r;
  logic [15:0] home_vel_r;
  logic [19:0] home_acc_r;

  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [5:0]    flags_r, flags_nxt;
  logic [6:0]    prev_r, prev_nxt;
  logic [15:0]   tpos_r, tpos_nxt;
  logic [15:0]   tvel_r, tvel_nxt;
  logic [19:0]   tacc_r, tacc_nxt;
  logic [PW-1:0] last_ptr;
  logic [19:0]   vel_x10;
  logic          tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_count_r <= aws_pkg::RST_WP_COUNT;
      home_pos_r <= aws_pkg::RST_HOME_POS;
      home_vel_r <= aws_pkg::RST_HOME_VEL;
      home_acc_r <= aws_pkg::RST_HOME_ACC;
    end else if (cfg_we) begin
      case (cfg_index)
        aws_pkg::CFG_WP_COUNT: wp_count_r <= cfg_data[3:0];
        aws_pkg::CFG_HOME_POS: home_pos_r <= cfg_data[15:0];
        aws_pkg::CFG_HOME_VEL: home_vel_r <= cfg_data[15:0];
        aws_pkg::CFG_HOME_ACC: home_acc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // last waypoint of a run; a count of zero runs one waypoint
  always_comb begin
    if (wp_count_r == 4'd0) begin
      last_ptr = '0;
    end else if (int'(wp_count_r) > MAX_WAYPOINTS) begin
      last_ptr = PW'(MAX_WAYPOINTS - 1);
    end else begin
      last_ptr = PW'(wp_count_r - 4'd1);
    end
  end

  assign vel_x10 = ({4'd0, rd_vel} << 3) + ({4'd0, rd_vel} << 1);
  assign tick    = acc && (in_req_type == aws_pkg::REQ_TICK);

  assign wr_en   = acc && (in_req_type == aws_pkg::REQ_WRITE) &&
                   (int'(in_wp_index) < MAX_WAYPOINTS);
  assign wr_addr = PW'(in_wp_index);
  assign rd_addr = ptr_nxt;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    flags_nxt = flags_r;
    prev_nxt  = prev_r;
    tpos_nxt  = tpos_r;
    tvel_nxt  = tvel_r;
    tacc_nxt  = tacc_r;
    if (tick) begin
      flags_nxt[aws_pkg::LF_HOME]  = flags_r[aws_pkg::LF_HOME]  | in_commands[aws_pkg::CMD_HOME];
      flags_nxt[aws_pkg::LF_START] = flags_r[aws_pkg::LF_START] | in_commands[aws_pkg::CMD_START];
      flags_nxt[aws_pkg::LF_STOP]  = flags_r[aws_pkg::LF_STOP]  | in_commands[aws_pkg::CMD_STOP];
      case (state_r)
        aws_pkg::ST_ACTIVE: begin
          if (prev_r[aws_pkg::AX_ACTIVE]) state_nxt = aws_pkg::ST_POWER;
        end
        aws_pkg::ST_POWER: begin
          if (prev_r[aws_pkg::AX_POWER]) state_nxt = aws_pkg::ST_HOMING;
        end
        aws_pkg::ST_HOMING: begin
          if (prev_r[aws_pkg::AX_HOMED]) begin
            flags_nxt[aws_pkg::LF_DHOME] = 1'b0;
            flags_nxt[aws_pkg::LF_HOME]  = 1'b0;
            state_nxt = aws_pkg::ST_WAIT;
          end
        end
        aws_pkg::ST_UPD: begin
          tpos_nxt = rd_pos;
          tvel_nxt = rd_vel;
          tacc_nxt = vel_x10;
          flags_nxt[aws_pkg::LF_UPDATE] = 1'b1;
          if (prev_r[aws_pkg::AX_UPDDONE]) state_nxt = aws_pkg::ST_MOVE1;
        end
        aws_pkg::ST_MOVE1: begin
          flags_nxt[aws_pkg::LF_MOVE] = 1'b1;
          if (prev_r[aws_pkg::AX_MOVING]) state_nxt = aws_pkg::ST_MOVE2;
        end
        aws_pkg::ST_MOVE2: begin
          if (flags_nxt[aws_pkg::LF_STOP]) begin
            state_nxt = aws_pkg::ST_STOP;
          end else if (prev_r[aws_pkg::AX_INPOS]) begin
            flags_nxt[aws_pkg::LF_MOVE] = 1'b0;
            if (ptr_r >= last_ptr) begin
              state_nxt = aws_pkg::ST_WAIT;
            end else begin
              ptr_nxt   = ptr_r + 1'b1;
              state_nxt = aws_pkg::ST_UPD;
            end
          end
        end
        aws_pkg::ST_HUPD: begin
          tpos_nxt = home_pos_r;
          tvel_nxt = home_vel_r;
          tacc_nxt = home_acc_r;
          flags_nxt[aws_pkg::LF_UPDATE] = 1'b1;
          if (prev_r[aws_pkg::AX_UPDDONE]) state_nxt = aws_pkg::ST_HMOVE1;
        end
        aws_pkg::ST_HMOVE1: begin
          flags_nxt[aws_pkg::LF_MOVE] = 1'b1;
          if (prev_r[aws_pkg::AX_MOVING]) state_nxt = aws_pkg::ST_HMOVE2;
        end
        aws_pkg::ST_HMOVE2: begin
          if (prev_r[aws_pkg::AX_INPOS]) begin
            flags_nxt[aws_pkg::LF_MOVE] = 1'b0;
            flags_nxt[aws_pkg::LF_HOME] = 1'b0;
            state_nxt = aws_pkg::ST_WAIT;
          end
        end
        aws_pkg::ST_STOP: begin
          flags_nxt[aws_pkg::LF_STOP]  = 1'b0;
          flags_nxt[aws_pkg::LF_START] = 1'b0;
          flags_nxt[aws_pkg::LF_MOVE]  = 1'b0;
          if (!prev_r[aws_pkg::AX_MOVING]) state_nxt = aws_pkg::ST_WAIT;
        end
        aws_pkg::ST_ERROR: begin
          flags_nxt[aws_pkg::LF_HOME]   = 1'b0;
          flags_nxt[aws_pkg::LF_UPDATE] = 1'b0;
          flags_nxt[aws_pkg::LF_STOP]   = 1'b0;
          flags_nxt[aws_pkg::LF_START]  = 1'b0;
          flags_nxt[aws_pkg::LF_MOVE]   = 1'b0;
          if (!prev_r[aws_pkg::AX_ERROR]) state_nxt = aws_pkg::ST_WAIT;
        end
        default: begin
          // idle wait, also taken by unused codes; start outranks home
          state_nxt = aws_pkg::ST_WAIT;
          if (flags_nxt[aws_pkg::LF_HOME]) state_nxt = aws_pkg::ST_HUPD;
          if (flags_nxt[aws_pkg::LF_START]) begin
            ptr_nxt   = '0;
            state_nxt = aws_pkg::ST_UPD;
          end
        end
      endcase
      if (flags_nxt[aws_pkg::LF_HOME] && !prev_r[aws_pkg::AX_HOMED]) begin
        flags_nxt[aws_pkg::LF_DHOME] = 1'b1;
      end
      prev_nxt = in_axis_status;
      // current-beat axis error overrides everything
      if (in_axis_status[aws_pkg::AX_ERROR]) state_nxt = aws_pkg::ST_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aws_pkg::ST_ACTIVE;
      ptr_r   <= '0;
      flags_r <= '0;
      prev_r  <= '0;
      tpos_r  <= '0;
      tvel_r  <= '0;
      tacc_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      flags_r <= flags_nxt;
      prev_r  <= prev_nxt;
      tpos_r  <= tpos_nxt;
      tvel_r  <= tvel_nxt;
      tacc_r  <= tacc_nxt;
    end
  end

  always_comb begin
    result.drive_position    = tpos_nxt;
    result.drive_velocity    = tvel_nxt;
    result.drive_acc_dec     = tacc_nxt;
    result.drive_power       = tick & in_commands[aws_pkg::CMD_POWER];
    result.drive_home        = flags_nxt[aws_pkg::LF_DHOME];
    result.drive_error_reset = tick & in_commands[aws_pkg::CMD_ERESET];
    result.drive_update      = flags_nxt[aws_pkg::LF_UPDATE];
    result.drive_move        = flags_nxt[aws_pkg::LF_MOVE];
    result.state_code        = state_nxt;
    result.waypoint_number   = 3'(ptr_nxt);
  end

  `AWS_ASSERT_NXT(a_write_holds_state, clk, rst_n,
                  acc && (in_req_type == aws_pkg::REQ_WRITE),
                  $stable(state_r) && $stable(ptr_r))
  `AWS_ASSERT_NXT(a_axis_error_forces, clk, rst_n,
                  tick && in_axis_status[aws_pkg::AX_ERROR],
                  state_r == aws_pkg::ST_ERROR)
  `AWS_ASSERT_NXT(a_error_drops_moves, clk, rst_n,
                  tick && (state_r == aws_pkg::ST_ERROR),
                  !flags_r[aws_pkg::LF_MOVE] && !flags_r[aws_pkg::LF_UPDATE])
  `AWS_ASSERT_IMP(a_ptr_in_table, clk, rst_n, 1'b1, int'(ptr_r) < MAX_WAYPOINTS)

endmodule

>>> rtl/aws_out_skid.sv
// Result register plus one skid entry between the sequencer and the receiver.
// Uses aws_pkg::result_t for the beat payload.
module aws_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  aws_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output aws_pkg::result_t out_data
);

  logic             out_valid_r;
  logic             skid_valid_r;
  aws_pkg::result_t out_data_r;
  aws_pkg::result_t skid_data_r;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/axis_waypoint_sequencer.sv
// Single-axis waypoint sequencer with valid/stall channels and a write port.
// Uses aws_pkg, aws_wp_table, aws_core and aws_out_skid.
//
// Each input beat is either a tick (commands plus the axis drive's status)
// or a waypoint write (slot, position, velocity). Every accepted beat gives
// exactly one result beat: drive targets, drive request bits, state code and
// current waypoint number. A write beat does not step the sequencer and
// reports power and error reset as zero.
// The result is registered in the output register as the beat is accepted,
// or in the skid entry when the receiver stalls, and shows on out_valid from
// there. Throughput is one beat per clock while in_stall is low; the waypoint
// table is read through a registered port whose address is the next-state
// waypoint pointer, so its read data matches the pointer register.
// When the receiver stalls, one more result lands in a skid entry; with the
// skid entry full, in_stall rises until the receiver takes a beat.
// Reset (synchronous, rst_n low) returns the sequencer to wait-for-active,
// clears latched requests and targets, restores the default waypoint table
// and the default home move, and empties the result path.
// Configuration writes are taken any cycle through cfg_we and apply from
// the next beat on; write them only while the block is idle.
module axis_waypoint_sequencer #(
  parameter int MAX_WAYPOINTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [2:0]  in_wp_index,
  input  logic [15:0] in_wp_position,
  input  logic [15:0] in_wp_velocity,
  input  logic [4:0]  in_commands,
  input  logic [6:0]  in_axis_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_drive_position,
  output logic [15:0] out_drive_velocity,
  output logic [19:0] out_drive_acc_dec,
  output logic        out_drive_power,
  output logic        out_drive_home,
  output logic        out_drive_error_reset,
  output logic        out_drive_update,
  output logic        out_drive_move,
  output logic [3:0]  out_state_code,
  output logic [2:0]  out_waypoint_number
);

  localparam int PW = $clog2(MAX_WAYPOINTS);

  logic             acc;
  logic             skid_full;
  logic             wr_en;
  logic [PW-1:0]    wr_addr;
  logic [PW-1:0]    rd_addr;
  logic [15:0]      rd_pos;
  logic [15:0]      rd_vel;
  aws_pkg::result_t core_result;
  aws_pkg::result_t out_data;

  assign in_stall = skid_full;
  assign acc      = in_valid && !skid_full;

  aws_wp_table #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS),
    .PW           (PW)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_pos (in_wp_position),
    .wr_vel (in_wp_velocity),
    .rd_addr(rd_addr),
    .rd_pos (rd_pos),
    .rd_vel (rd_vel)
  );

  aws_core #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS),
    .PW           (PW)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .acc           (acc),
    .in_req_type   (in_req_type),
    .in_wp_index   (in_wp_index),
    .in_commands   (in_commands),
    .in_axis_status(in_axis_status),
    .rd_pos        (rd_pos),
    .rd_vel        (rd_vel),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .result        (core_result)
  );

  aws_out_skid u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc),
    .push_data(core_result),
    .full     (skid_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign out_drive_position    = out_data.drive_position;
  assign out_drive_velocity    = out_data.drive_velocity;
  assign out_drive_acc_dec     = out_data.drive_acc_dec;
  assign out_drive_power       = out_data.drive_power;
  assign out_drive_home        = out_data.drive_home;
  assign out_drive_error_reset = out_data.drive_error_reset;
  assign out_drive_update      = out_data.drive_update;
  assign out_drive_move        = out_data.drive_move;
  assign out_state_code        = out_data.state_code;
  assign out_waypoint_number   = out_data.waypoint_number;

endmodule
